FILE: design/hsv2rgb_pkg.sv
// Shared types and constants for the 8-bit HSV to RGB converter.
package hsv2rgb_pkg;

  // Hue sector codes; the last sector also serves as the default.
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sector;
    logic [7:0] frac;
  } hue_split_t;

  localparam logic [7:0]  CHAN_MAX   = 8'd255;
  localparam logic [15:0] FULL_SQ    = 16'd65025;        // 255 * 255
  // floor(2^24 / 255) and floor(2^32 / 65025): estimates are low by at most one
  localparam logic [16:0] RECIP_255  = 17'd65793;
  localparam logic [16:0] RECIP_SQ   = 17'd66051;
  localparam logic [16:0] FULL_SQ_17 = 17'd65025;
  localparam logic [8:0]  DIV_255    = 9'd255;

endpackage

FILE: design/hsv2rgb_sector.sv
// Hue wrap, sector lookup and fraction numerator of six times hue over 255.
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic [7:0] hue,
  output hue_split_t split
);

  logic [7:0]  hue_w;
  logic [10:0] six_h;
  logic [10:0] base;
  sector_t     sec;

  always_comb begin
    hue_w = (hue == CHAN_MAX) ? 8'd0 : hue;
    six_h = {1'b0, hue_w, 2'b00} + {2'b00, hue_w, 1'b0};
    if (six_h >= 11'd1275) begin
      sec  = SEC_5;
      base = 11'd1275;
    end else if (six_h >= 11'd1020) begin
      sec  = SEC_4;
      base = 11'd1020;
    end else if (six_h >= 11'd765) begin
      sec  = SEC_3;
      base = 11'd765;
    end else if (six_h >= 11'd510) begin
      sec  = SEC_2;
      base = 11'd510;
    end else if (six_h >= 11'd255) begin
      sec  = SEC_1;
      base = 11'd255;
    end else begin
      sec  = SEC_0;
      base = 11'd0;
    end
    split.sector = sec;
    split.frac   = 8'((six_h - base));
  end

endmodule

FILE: design/hsv_to_rgb_8bit.sv
// Top level of the 8-bit HSV to RGB converter: a six-stage pipeline.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one HSV pixel per
//   transaction: in_hue (0..255, 255 is the same as 0), in_saturation and
//   in_brightness. The output channel (out_valid / out_stall) carries one
//   RGB pixel per transaction on out_red, out_green and out_blue.
//   Every input transaction yields exactly one output transaction, in order.
//
// Timing:
//   An input transaction passes through stage registers 1 to 6 to reach
//   out_valid. Throughput is one pixel per clock while nothing stalls; most
//   stages hold multiplies or adds/compares, and they advance independently.
//
// Stalls:
//   Each stage moves forward when it is empty or the stage after it moves,
//   so bubbles collapse. in_stall rises only when every stage holds a pixel
//   and the receiver stalls the output register; the output payload holds.
//
// Reset:
//   rst_n (synchronous, active low) clears all valid bits; no pixel is in
//   flight after reset. The payload registers are not reset.
module hsv_to_rgb_8bit
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  // Stage valid bits and advance enables, index 1..6 (6 is the output)
  logic [6:1] vld_r;
  logic [6:1] vld_nxt;
  logic [6:1] adv;

  hue_split_t split;

  // Stage 1: sector split
  hue_split_t s1_split_r;
  logic [7:0] s1_sat_r, s1_val_r, s1_nsat_r;
  logic       s1_grey_r;
  // Stage 2: first products
  sector_t    s2_sec_r;
  logic [7:0] s2_val_r;
  logic       s2_grey_r;
  logic [15:0] s2_sf_r, s2_sg_r, s2_vp_r;
  // Stage 3: complements against 65025
  sector_t    s3_sec_r;
  logic [7:0] s3_val_r;
  logic       s3_grey_r;
  logic [15:0] s3_a_r, s3_b_r, s3_vp_r;
  // Stage 4: scaled by brightness
  sector_t    s4_sec_r;
  logic [7:0] s4_val_r;
  logic       s4_grey_r;
  logic [23:0] s4_yq_r, s4_yt_r;
  logic [15:0] s4_vp_r;
  // Stage 5: reciprocal estimates
  sector_t    s5_sec_r;
  logic [7:0] s5_val_r;
  logic       s5_grey_r;
  logic [23:0] s5_yq_r, s5_yt_r;
  logic [15:0] s5_vp_r;
  logic [8:0]  s5_eq_r, s5_et_r, s5_ep_r;
  // Stage 6: output register
  logic [7:0] red_r, green_r, blue_r;

  logic [40:0] prod_q, prod_t;
  logic [32:0] prod_p;
  logic [25:0] back_q, back_t;
  logic [16:0] back_p;
  logic [25:0] rem_q, rem_t;
  logic [16:0] rem_p;
  logic [8:0]  quo_q, quo_t, quo_p;
  logic [7:0]  q_c, t_c, p_c;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;

  hsv2rgb_sector u_sector (
    .hue   (in_hue),
    .split (split)
  );

  // Ready chain: a stage advances if it is empty or its successor advances
  always_comb begin
    adv[6] = !vld_r[6] || !out_stall;
    adv[5] = !vld_r[5] || adv[6];
    adv[4] = !vld_r[4] || adv[5];
    adv[3] = !vld_r[3] || adv[4];
    adv[2] = !vld_r[2] || adv[3];
    adv[1] = !vld_r[1] || adv[2];
    vld_nxt = vld_r;
    if (adv[1]) vld_nxt[1] = in_valid;
    if (adv[2]) vld_nxt[2] = vld_r[1];
    if (adv[3]) vld_nxt[3] = vld_r[2];
    if (adv[4]) vld_nxt[4] = vld_r[3];
    if (adv[5]) vld_nxt[5] = vld_r[4];
    if (adv[6]) vld_nxt[6] = vld_r[5];
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Quotient estimates from reciprocal multiplies (low by at most one)
  always_comb begin
    prod_q = 41'(s4_yq_r) * 41'(RECIP_SQ);
    prod_t = 41'(s4_yt_r) * 41'(RECIP_SQ);
    prod_p = 33'(s4_vp_r) * 33'(RECIP_255);
  end

  // Correct the estimates, saturate, then route channels by sector (grey: all brightness)
  always_comb begin
    back_q = 26'(s5_eq_r) * 26'(FULL_SQ_17);
    back_t = 26'(s5_et_r) * 26'(FULL_SQ_17);
    back_p = 17'(s5_ep_r) * 17'(DIV_255);
    rem_q  = 26'(s5_yq_r) - back_q;
    rem_t  = 26'(s5_yt_r) - back_t;
    rem_p  = 17'(s5_vp_r) - back_p;
    quo_q  = (rem_q >= 26'(FULL_SQ_17)) ? s5_eq_r + 9'd1 : s5_eq_r;
    quo_t  = (rem_t >= 26'(FULL_SQ_17)) ? s5_et_r + 9'd1 : s5_et_r;
    quo_p  = (rem_p >= 17'(DIV_255))    ? s5_ep_r + 9'd1 : s5_ep_r;
    q_c = quo_q[8] ? CHAN_MAX : quo_q[7:0];
    t_c = quo_t[8] ? CHAN_MAX : quo_t[7:0];
    p_c = quo_p[8] ? CHAN_MAX : quo_p[7:0];
    if (s5_grey_r) begin
      red_nxt   = s5_val_r;
      green_nxt = s5_val_r;
      blue_nxt  = s5_val_r;
    end else begin
      case (s5_sec_r)
        SEC_0: begin
          red_nxt = s5_val_r; green_nxt = t_c; blue_nxt = p_c;
        end
        SEC_1: begin
          red_nxt = q_c; green_nxt = s5_val_r; blue_nxt = p_c;
        end
        SEC_2: begin
          red_nxt = p_c; green_nxt = s5_val_r; blue_nxt = t_c;
        end
        SEC_3: begin
          red_nxt = p_c; green_nxt = q_c; blue_nxt = s5_val_r;
        end
        SEC_4: begin
          red_nxt = t_c; green_nxt = p_c; blue_nxt = s5_val_r;
        end
        default: begin
          red_nxt = s5_val_r; green_nxt = p_c; blue_nxt = q_c;
        end
      endcase
    end
  end

  // Payload registers: load when the stage advances and its source is valid
  always_ff @(posedge clk) begin
    if (adv[1] && in_valid) begin
      s1_split_r <= split;
      s1_sat_r   <= in_saturation;
      s1_val_r   <= in_brightness;
      s1_nsat_r  <= CHAN_MAX - in_saturation;
      s1_grey_r  <= (in_saturation == 8'd0);
    end
    if (adv[2] && vld_r[1]) begin
      s2_sec_r  <= s1_split_r.sector;
      s2_val_r  <= s1_val_r;
      s2_grey_r <= s1_grey_r;
      s2_sf_r   <= 16'(s1_sat_r) * 16'(s1_split_r.frac);
      s2_sg_r   <= 16'(s1_sat_r) * 16'(CHAN_MAX - s1_split_r.frac);
      s2_vp_r   <= 16'(s1_val_r) * 16'(s1_nsat_r);
    end
    if (adv[3] && vld_r[2]) begin
      s3_sec_r  <= s2_sec_r;
      s3_val_r  <= s2_val_r;
      s3_grey_r <= s2_grey_r;
      s3_a_r    <= FULL_SQ - s2_sf_r;
      s3_b_r    <= FULL_SQ - s2_sg_r;
      s3_vp_r   <= s2_vp_r;
    end
    if (adv[4] && vld_r[3]) begin
      s4_sec_r  <= s3_sec_r;
      s4_val_r  <= s3_val_r;
      s4_grey_r <= s3_grey_r;
      s4_yq_r   <= 24'(s3_val_r) * 24'(s3_a_r);
      s4_yt_r   <= 24'(s3_val_r) * 24'(s3_b_r);
      s4_vp_r   <= s3_vp_r;
    end
    if (adv[5] && vld_r[4]) begin
      s5_sec_r  <= s4_sec_r;
      s5_val_r  <= s4_val_r;
      s5_grey_r <= s4_grey_r;
      s5_yq_r   <= s4_yq_r;
      s5_yt_r   <= s4_yt_r;
      s5_vp_r   <= s4_vp_r;
      s5_eq_r   <= prod_q[40:32];
      s5_et_r   <= prod_t[40:32];
      s5_ep_r   <= prod_p[32:24];
    end
    if (adv[6] && vld_r[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vld_r[6];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

FILE: design/hsv2rgb_chk.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
module hsv2rgb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_hue,
  input logic [7:0] in_saturation,
  input logic [7:0] in_brightness,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // A stalled input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_hue) &&
      $stable(in_saturation) && $stable(in_brightness))
    else $error("stalled input transaction changed");

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("stalled output transaction changed");

  // Reset leaves nothing in flight
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Backpressure reaches the input only when the output is full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while output register empty");

  // A draining output frees the whole pipeline
  a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind hsv_to_rgb_8bit hsv2rgb_chk u_hsv2rgb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_hue        (in_hue),
  .in_saturation (in_saturation),
  .in_brightness (in_brightness),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);

FILE: dv/hsv_rgb_checker.sv
// Channel monitor, pixel color predictor and scoreboard for hsv_to_rgb_8bit.
module hsv_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  output int         pixels_pending,
  output int         mismatch_count
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  rgb_pixel_t rgb_expected_q[$];

  function automatic logic [7:0] clip8(int unsigned x);
    return (x > 255) ? 8'd255 : x[7:0];
  endfunction

  // Exact integer floors; all terms lie within 0..brightness.
  function automatic rgb_pixel_t hsv_to_rgb_predict(logic [7:0] hue, logic [7:0] sat,
                                                    logic [7:0] val);
    int unsigned h, s, v, frac, p, q, t;
    sector_t     sec;
    rgb_pixel_t  px;
    s = sat;
    v = val;
    if (s == 0) begin
      px = '{red: val, green: val, blue: val};
    end else begin
      h    = (hue == 8'd255) ? 0 : hue;
      sec  = sector_t'((6 * h) / 255);
      frac = (6 * h) % 255;
      p    = (v * (255 - s)) / 255;
      q    = (v * (65025 - s * frac)) / 65025;
      t    = (v * (65025 - s * (255 - frac))) / 65025;
      case (sec)
        SEC_0:   px = '{red: clip8(v), green: clip8(t), blue: clip8(p)};
        SEC_1:   px = '{red: clip8(q), green: clip8(v), blue: clip8(p)};
        SEC_2:   px = '{red: clip8(p), green: clip8(v), blue: clip8(t)};
        SEC_3:   px = '{red: clip8(p), green: clip8(q), blue: clip8(v)};
        SEC_4:   px = '{red: clip8(t), green: clip8(p), blue: clip8(v)};
        default: px = '{red: clip8(v), green: clip8(p), blue: clip8(q)};
      endcase
    end
    return px;
  endfunction

  task automatic check_channel(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    rgb_pixel_t want;
    if (rst_n) begin
      // Retire the output transaction first, then queue the new input one.
      if (out_valid && !out_stall) begin
        if (rgb_expected_q.size() == 0) begin
          $error("output pixel %0d/%0d/%0d with no input pixel pending",
                 out_red, out_green, out_blue);
          mismatch_count++;
        end else begin
          want = rgb_expected_q.pop_front();
          check_channel("red", want.red, out_red);
          check_channel("green", want.green, out_green);
          check_channel("blue", want.blue, out_blue);
        end
      end
      if (in_valid && !in_stall)
        rgb_expected_q.push_back(hsv_to_rgb_predict(in_hue, in_saturation, in_brightness));
    end
    pixels_pending <= rgb_expected_q.size();
  end

endmodule

FILE: dv/testbench.sv
// Stimulus, flow-control pressure and verdict for the hsv_to_rgb_8bit converter.
module testbench;

  localparam int RANDOM_PIXELS = 1600;
  localparam int DRAIN_CYCLES  = 20;    // pipeline is six deep; leave plenty of margin
  localparam int HOLD_CYCLES   = 60;    // long enough to back the whole pipeline up
  localparam int IDLE_PERCENT  = 22;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_hue;
  logic [7:0] in_saturation;
  logic [7:0] in_brightness;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  int pixels_pending;
  int mismatch_count;

  // Flow-control knobs shared by the sender and the receiver processes.
  bit sender_calm;
  bit receiver_calm;
  bit hold_request;

  hsv_to_rgb_8bit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  hsv_rgb_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .pixels_pending(pixels_pending),
    .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #1000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Offer one pixel, optionally after a random gap, and hold it until the
  // transaction completes. Valid stays high straight into the next pixel
  // when there is no gap, so it is never dropped and raised in one step.
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] val);
    int gap;
    gap = 0;
    if (!sender_calm)
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted pixel has come out.
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
  endtask

  // Bias a field toward its extremes a quarter of the time.
  function automatic logic [7:0] pick_field();
    logic [7:0] corners [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(3) == 0)
      return corners[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (!receiver_calm && $urandom_range(99) < IDLE_PERCENT) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = 8'd0;
    in_saturation = 8'd0;
    in_brightness = 8'd0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    hold_request  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every sector edge at full saturation and brightness,
    // hue wrapping at full circle, grey pixels, and extreme terms.
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd42,  8'd255, 8'd255);
    send_pixel(8'd43,  8'd255, 8'd255);
    send_pixel(8'd85,  8'd255, 8'd255);
    send_pixel(8'd127, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd255, 8'd255);
    send_pixel(8'd212, 8'd255, 8'd255);
    send_pixel(8'd213, 8'd255, 8'd255);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd200);
    send_pixel(8'd100, 8'd0,   8'd200);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd37,  8'd1,   8'd255);
    send_pixel(8'd150, 8'd255, 8'd0);
    send_pixel(8'd200, 8'd128, 8'd1);
    send_pixel(8'd60,  8'd254, 8'd254);
    send_pixel(8'd191, 8'd170, 8'd85);
    drain_pixels();

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      // Back the pipeline up: long receiver hold with the sender pushing hard.
      if (n == 200) begin
        hold_request = 1'b1;
        sender_calm  = 1'b1;
      end
      if (n == 300)
        sender_calm = 1'b0;
      // Full-rate stretch with no idling on either side.
      if (n == 500) begin
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
      end
      if (n == 800) begin
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
      end
      // Pause the sender until the converter is empty.
      if (n == 1000)
        drain_pixels();
      send_pixel(pick_field(), pick_field(), pick_field());
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
